FILE: rtl/rtst_pkg.sv
// Shared types and constants for the round-trip statistics tracker.
// Used by rtst_ctrl, rtst_dp and the top level round_trip_stats_tracker.
package rtst_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COUNT_BITS  = 32;
   localparam int STEP_BITS   = $clog2(SAMPLE_BITS);
   localparam int RSP_BITS    = 3 * SAMPLE_BITS + COUNT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MEAN,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_sample;
      logic div_step;
      logic mean_update;
      logic out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic first_sample;
   } ctrl_sts_type;

endpackage

FILE: rtl/rtst_ctrl.sv
// Controller state machine for the round-trip statistics tracker.
// Depends on rtst_pkg; drives the rtst_dp datapath through command signals.
module rtst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  rtst_pkg::ctrl_sts_type sts,
   output rtst_pkg::ctrl_cmd_type cmd
);
   import rtst_pkg::*;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  req_beat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // State, step counter and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      cmd              = '0;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               cmd.take_sample = 1'b1;
               step_in         = '0;
               state_in        = sts.first_sample ? ST_OUT : ST_DIV;
            end
         end
         ST_DIV: begin
            // One quotient bit per cycle, most significant first.
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(SAMPLE_BITS - 1)) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.mean_update = 1'b1;
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            // Load the result register once its previous beat has left.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/rtst_dp.sv
// Datapath of the round-trip statistics tracker: statistic registers,
// a bit-serial restoring divider and the result register. Depends on rtst_pkg.
module rtst_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [rtst_pkg::SAMPLE_BITS-1:0]   sample,
   input  rtst_pkg::ctrl_cmd_type             cmd,
   output rtst_pkg::ctrl_sts_type             sts,
   output logic [rtst_pkg::RSP_BITS-1:0]      rsp_data
);
   import rtst_pkg::*;

   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   up_ff, up_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] quot_ff, quot_in;
   logic [RSP_BITS-1:0]    out_ff, out_in;
   logic                   first;
   logic                   up_now;
   logic [SAMPLE_BITS-1:0] mag;
   logic [COUNT_BITS:0]    trial;
   logic [COUNT_BITS:0]    diff;

   assign first            = (count_ff == '0);
   assign sts.first_sample = first;
   assign rsp_data         = out_ff;

   // Distance of the new sample from the mean and its direction.
   assign up_now = (sample >= mean_ff);
   assign mag    = up_now ? (sample - mean_ff) : (mean_ff - sample);

   // One restoring division step: shift in the next dividend bit, try subtract.
   assign trial = {rem_ff, quot_ff[SAMPLE_BITS-1]};
   assign diff  = trial - {1'b0, count_ff};

   // Count register, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      min_ff  <= min_in;
      max_ff  <= max_in;
      mean_ff <= mean_in;
      up_ff   <= up_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      out_ff  <= out_in;
   end

   // Next values of statistics, divider and result register.
   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      mean_in  = mean_ff;
      count_in = count_ff;
      up_in    = up_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      out_in   = out_ff;
      if (cmd.take_sample) begin
         if (first) begin
            min_in   = sample;
            max_in   = sample;
            mean_in  = sample;
            count_in = COUNT_BITS'(1);
         end else begin
            if (sample < min_ff) begin
               min_in = sample;
            end
            if (sample > max_ff) begin
               max_in = sample;
            end
            // The count holds at its maximum instead of wrapping.
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            up_in   = up_now;
            rem_in  = '0;
            quot_in = mag;
         end
      end
      if (cmd.div_step) begin
         if (!diff[COUNT_BITS]) begin
            rem_in  = diff[COUNT_BITS-1:0];
            quot_in = {quot_ff[SAMPLE_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial[COUNT_BITS-1:0];
            quot_in = {quot_ff[SAMPLE_BITS-2:0], 1'b0};
         end
      end
      if (cmd.mean_update) begin
         mean_in = up_ff ? (mean_ff + quot_ff) : (mean_ff - quot_ff);
      end
      if (cmd.out_load) begin
         out_in = {count_ff, mean_ff, max_ff, min_ff};
      end
   end

endmodule

FILE: rtl/round_trip_stats_tracker.sv
// Round-trip statistics tracker: min, max, running mean and sample count.
// rsp_tvalid is registered; it rises once the controller has gone from ST_IDLE to
// ST_OUT for the first sample after reset, or through ST_DIV (bit-serial divider),
// ST_MEAN and ST_OUT for later ones. No new sample is taken until back in ST_IDLE.
// Reset: synchronous, active high; clears the count so the next sample is first.
// Depends on rtst_pkg, rtst_ctrl and rtst_dp.
module round_trip_stats_tracker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // [23:0] rtt_us
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata    // [23:0] min_us, [47:24] max_us,
                                     // [71:48] mean_us, [103:72] sample_count
);
   import rtst_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // Sequencing of one sample through update, division and output.
   rtst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Statistic registers, divider and result register.
   rtst_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .sample   (req_tdata[SAMPLE_BITS-1:0]),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_tdata)
   );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for round_trip_stats_tracker: checks min, max, running mean and count per sample.
// A per-sample predictor runs beside the block, and every result beat is compared field by field.
// Depends on rtst_pkg and the block's RTL only.
module tb_top;
   import rtst_pkg::*;

   // Result beat layout, lowest field in the lowest bits.
   typedef struct packed {
      logic [COUNT_BITS-1:0]  sample_count;
      logic [SAMPLE_BITS-1:0] mean_us;
      logic [SAMPLE_BITS-1:0] max_us;
      logic [SAMPLE_BITS-1:0] min_us;
   } rtt_stats_type;

   localparam logic [SAMPLE_BITS-1:0] RTT_TOP = {SAMPLE_BITS{1'b1}};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;   // [23:0] rtt_us
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;        // [23:0] min_us, [47:24] max_us,
                                   // [71:48] mean_us, [103:72] sample_count

   round_trip_stats_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predicted statistics, updated as each sample beat is accepted.
   logic [SAMPLE_BITS-1:0] trk_min = '0;
   logic [SAMPLE_BITS-1:0] trk_max = '0;
   logic [SAMPLE_BITS-1:0] trk_mean = '0;
   logic [COUNT_BITS-1:0]  trk_count = '0;

   rtt_stats_type pending_stats[$];
   rtt_stats_type got_stats;
   rtt_stats_type want_stats;
   int         mismatch_count = 0;
   int         burst_left = 0;
   bit         gaps_on = 1'b1;

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Reset is held high from the start and released on a falling edge.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Fold one sample into the predicted statistics and return the new values.
   function automatic rtt_stats_type advance_stats(input logic [SAMPLE_BITS-1:0] rtt);
      rtt_stats_type          stats;
      logic [SAMPLE_BITS-1:0] gap_mag;
      logic [63:0]            quot;
      if (trk_count == '0) begin
         trk_min   = rtt;
         trk_max   = rtt;
         trk_mean  = rtt;
         trk_count = 1;
      end else begin
         if (rtt < trk_min) trk_min = rtt;
         if (rtt > trk_max) trk_max = rtt;
         // The count sticks at all ones instead of wrapping.
         if (trk_count != '1) trk_count = trk_count + 1'b1;
         // Unsigned magnitude over an unsigned count truncates toward zero.
         if (rtt >= trk_mean) begin
            gap_mag  = rtt - trk_mean;
            quot     = 64'(gap_mag) / 64'(trk_count);
            trk_mean = trk_mean + quot[SAMPLE_BITS-1:0];
         end else begin
            gap_mag  = trk_mean - rtt;
            quot     = 64'(gap_mag) / 64'(trk_count);
            trk_mean = trk_mean - quot[SAMPLE_BITS-1:0];
         end
      end
      stats.min_us       = trk_min;
      stats.max_us       = trk_max;
      stats.mean_us      = trk_mean;
      stats.sample_count = trk_count;
      return stats;
   endfunction

   // Send one sample beat; the sender works in bursts with random gaps between them.
   // Called at a falling edge and returns at a falling edge with tvalid still high.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] rtt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_on) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
            if (gap > 0) begin
               req_tvalid = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      burst_left = burst_left - 1;
      req_tvalid = 1'b1;
      req_tdata  = rtt;
      do @(posedge clock); while (!req_tready);
      pending_stats.push_back(advance_stats(rtt));
      @(negedge clock);
   endtask

   // Sample a value relative to the predicted mean, kept inside the field's range.
   function automatic logic [SAMPLE_BITS-1:0] near_mean(input longint offset);
      longint v;
      v = longint'(trk_mean) + offset;
      if (v < 0) v = 0;
      if (v > longint'(RTT_TOP)) v = longint'(RTT_TOP);
      return v[SAMPLE_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= 10)
         $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   // Each accepted result beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_stats = rsp_tdata;
         if (pending_stats.size() == 0) begin
            report_mismatch("unexpected result beat", '0, got_stats.sample_count);
         end else begin
            want_stats = pending_stats.pop_front();
            if (got_stats.min_us !== want_stats.min_us)
               report_mismatch("min_us", want_stats.min_us, got_stats.min_us);
            if (got_stats.max_us !== want_stats.max_us)
               report_mismatch("max_us", want_stats.max_us, got_stats.max_us);
            if (got_stats.mean_us !== want_stats.mean_us)
               report_mismatch("mean_us", want_stats.mean_us, got_stats.mean_us);
            if (got_stats.sample_count !== want_stats.sample_count)
               report_mismatch("sample_count", want_stats.sample_count,
                               got_stats.sample_count);
         end
      end
   end

   // The receiver stalls on its own pattern: open stretches, random stalls, periodic stalls.
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      int k;
      wait (!reset);
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(20, 200);
         for (k = 0; k < span; k++) begin
            case (mode)
               0: begin
                  rsp_tready = 1'b1;
               end
               1: begin
                  rsp_tready = ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_tready = ((k % 16) >= 5);
               end
            endcase
            @(negedge clock);
         end
      end
   end

   // The first sample after reset loads every statistic from the value.
   task automatic test_first_sample();
      send_sample(RTT_TOP);
   endtask

   // Field extremes, pulling the mean hard in both directions.
   task automatic test_field_extremes();
      send_sample('0);
      send_sample(RTT_TOP);
      send_sample(24'h000001);
      send_sample(24'hFFFFFE);
      send_sample(24'h800000);
      send_sample(24'h7FFFFF);
   endtask

   // Samples around the mean: no difference, differences below the new count that
   // truncate to zero, and differences of exactly one step.
   task automatic test_mean_truncation();
      send_sample(trk_mean);
      send_sample(near_mean(1));
      send_sample(near_mean(-1));
      send_sample(near_mean(longint'(trk_count)));
      send_sample(near_mean(longint'(trk_count) + 1));
      send_sample(near_mean(-(longint'(trk_count) + 1)));
      send_sample(near_mean(-(longint'(trk_count) + 2)));
   endtask

   // Alternating bit patterns so every sample bit toggles early.
   task automatic test_bit_patterns();
      send_sample(24'h555555);
      send_sample(24'hAAAAAA);
      send_sample(24'h0F0F0F);
      send_sample(24'hF0F0F0);
   endtask

   // Random samples: full range, extremes and values close to the mean, with
   // stretches where the sender never pauses.
   task automatic test_random_samples(input int n_items);
      int     i;
      int     kind;
      longint span;
      logic [SAMPLE_BITS-1:0] rtt;
      for (i = 0; i < n_items; i++) begin
         gaps_on = ((i / 150) % 3 != 1);
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            rtt = SAMPLE_BITS'($urandom_range(0, RTT_TOP));
         end else if (kind < 6) begin
            case ($urandom_range(0, 3))
               0: rtt = '0;
               1: rtt = RTT_TOP;
               2: rtt = 24'h000001;
               default: rtt = 24'hFFFFFE;
            endcase
         end else begin
            span = 2 * (longint'(trk_count) + 1);
            if ($urandom_range(0, 1) == 0)
               rtt = near_mean(longint'($urandom_range(0, span)));
            else
               rtt = near_mean(-longint'($urandom_range(0, span)));
         end
         send_sample(rtt);
      end
      gaps_on = 1'b1;
   endtask

   // Test sequence and final verdict.
   initial begin
      wait (!reset);
      @(negedge clock);
      test_first_sample();
      test_field_extremes();
      test_mean_truncation();
      test_bit_patterns();
      test_random_samples(900);
      req_tvalid = 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_stats.size() == 0) begin
         $display("PASS round_trip_stats_tracker");
      end else begin
         $display("FAIL round_trip_stats_tracker");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #10000000;
      $display("FAIL round_trip_stats_tracker");
      $finish;
   end

endmodule
